### src/weadc_pkg.sv
// Shared types and constants for the windowed energy activity detector.
`timescale 1ns / 1ps

package weadc_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int WINDOW_BITS    = 16;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS - 1;
    localparam int THR_BITS       = 31;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OFFSET_BITS    = 32;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANS        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_LEN      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_LEN      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENERGY_THR   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_START = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } in_item_t;

    typedef struct packed {
        logic                   any_active;
        logic [OFFSET_BITS-1:0] active_start;
        logic [OFFSET_BITS-1:0] active_end;
    } out_item_t;

    typedef struct packed {
        logic [3:0]             chans_per_frame;
        logic [15:0]            win_len;
        logic [23:0]            pad_len;
        logic [THR_BITS-1:0]    energy_thr;
        logic [30:0]            region_start;
    } cfg_t;

    // Finished region handed from the accumulator to the output formatter
    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] first_off;
        logic [OFFSET_BITS-1:0] last_off;
        logic [OFFSET_BITS-1:0] frames;
    } region_sum_t;

endpackage

### src/weadc_square_stage.sv
// Input register stage: capture one sample item and square it.
`timescale 1ns / 1ps

module weadc_square_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  weadc_pkg::in_item_t                 in_data,
    input  logic                                take,
    output logic                                sq_valid,
    output logic [weadc_pkg::SQ_BITS-1:0]       sq_value,
    output logic                                sq_last
);
    import weadc_pkg::*;

    logic                          valid_reg;
    logic [SQ_BITS-1:0]            sq_reg;
    logic                          last_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod;

    assign prod     = in_data.sample * in_data.sample;
    assign in_stall = valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            sq_reg   <= prod[SQ_BITS-1:0];
            last_reg <= in_data.last_sample;
        end
    end

    assign sq_valid = valid_reg;
    assign sq_value = sq_reg;
    assign sq_last  = last_reg;

endmodule

### src/weadc_accum.sv
// Per-sample accumulator: frame and window tracking, window test, region summary.
`timescale 1ns / 1ps

module weadc_accum #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  weadc_pkg::cfg_t                     cfg,
    input  logic                                sq_valid,
    input  logic [weadc_pkg::SQ_BITS-1:0]       sq_value,
    input  logic                                sq_last,
    output logic                                take,
    output logic                                sum_valid,
    output weadc_pkg::region_sum_t              sum_data,
    input  logic                                sum_ready
);
    import weadc_pkg::*;

    localparam int CH_BITS  = $clog2(MAX_CHANNELS + 1);
    localparam int CNT_BITS = $clog2((2**WINDOW_BITS - 1) * MAX_CHANNELS + 1);
    localparam int SUM_BITS = CNT_BITS + 2 * SAMPLE_BITS - 2;
    localparam int LIM_BITS = THR_BITS + CNT_BITS;

    logic [SUM_BITS-1:0]    energy_reg, energy_next, energy_inc;
    logic [CNT_BITS-1:0]    count_reg, count_next, count_inc;
    logic [CH_BITS-1:0]     chan_reg, chan_next, chan_inc;
    logic [OFFSET_BITS-1:0] frame_reg, frame_next, frame_inc;
    logic [OFFSET_BITS-1:0] wstart_reg, wstart_next;
    logic [OFFSET_BITS-1:0] first_reg, first_next, first_upd;
    logic [OFFSET_BITS-1:0] lastoff_reg, lastoff_next, lastoff_upd;
    logic                   found_reg, found_next, found_upd;
    logic                   sv_reg, sv_next;
    region_sum_t            sd_reg;

    logic [4:0]             eff_ch;
    logic [WINDOW_BITS-1:0] eff_win;
    logic [LIM_BITS-1:0]    limit;
    logic                   frame_done, win_close, active, fire, sum_free;

    assign sum_free = !sv_reg || sum_ready;
    assign fire     = sq_valid && (!sq_last || sum_free);
    assign take     = fire;

    always_comb
    begin
        if (cfg.chans_per_frame == 4'd0)
            eff_ch = 5'd1;
        else if (5'(cfg.chans_per_frame) > 5'(MAX_CHANNELS))
            eff_ch = 5'(MAX_CHANNELS);
        else
            eff_ch = 5'(cfg.chans_per_frame);

        eff_win = (cfg.win_len[WINDOW_BITS-1:0] == '0)
                  ? WINDOW_BITS'(1) : cfg.win_len[WINDOW_BITS-1:0];
    end

    assign energy_inc = energy_reg + SUM_BITS'(sq_value);
    assign count_inc  = count_reg + CNT_BITS'(1);
    assign chan_inc   = chan_reg + CH_BITS'(1);
    assign frame_done = (5'(chan_inc) >= eff_ch) || sq_last;
    assign frame_inc  = frame_done ? frame_reg + OFFSET_BITS'(1) : frame_reg;
    assign win_close  = frame_done
                        && (((frame_inc - wstart_reg) >= OFFSET_BITS'(eff_win)) || sq_last);
    assign limit      = LIM_BITS'(cfg.energy_thr) * LIM_BITS'(count_inc);
    assign active     = win_close && (LIM_BITS'(energy_inc) > limit);

    assign first_upd   = (active && !found_reg) ? wstart_reg : first_reg;
    assign lastoff_upd = active ? frame_inc : lastoff_reg;
    assign found_upd   = found_reg || active;

    always_comb
    begin
        energy_next  = energy_reg;
        count_next   = count_reg;
        chan_next    = chan_reg;
        frame_next   = frame_reg;
        wstart_next  = wstart_reg;
        first_next   = first_reg;
        lastoff_next = lastoff_reg;
        found_next   = found_reg;
        sv_next      = sum_free ? (fire && sq_last) : sv_reg;
        if (fire)
        begin
            if (sq_last)
            begin
                energy_next  = '0;
                count_next   = '0;
                chan_next    = '0;
                frame_next   = '0;
                wstart_next  = '0;
                first_next   = '0;
                lastoff_next = '0;
                found_next   = 1'b0;
            end
            else
            begin
                energy_next  = win_close ? '0 : energy_inc;
                count_next   = win_close ? '0 : count_inc;
                chan_next    = frame_done ? '0 : chan_inc;
                frame_next   = frame_inc;
                wstart_next  = win_close ? frame_inc : wstart_reg;
                first_next   = first_upd;
                lastoff_next = lastoff_upd;
                found_next   = found_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg  <= '0;
            count_reg   <= '0;
            chan_reg    <= '0;
            frame_reg   <= '0;
            wstart_reg  <= '0;
            first_reg   <= '0;
            lastoff_reg <= '0;
            found_reg   <= 1'b0;
            sv_reg      <= 1'b0;
        end
        else
        begin
            energy_reg  <= energy_next;
            count_reg   <= count_next;
            chan_reg    <= chan_next;
            frame_reg   <= frame_next;
            wstart_reg  <= wstart_next;
            first_reg   <= first_next;
            lastoff_reg <= lastoff_next;
            found_reg   <= found_next;
            sv_reg      <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && sq_last)
        begin
            sd_reg.found     <= found_upd;
            sd_reg.first_off <= first_upd;
            sd_reg.last_off  <= lastoff_upd;
            sd_reg.frames    <= frame_inc;
        end
    end

    assign sum_valid = sv_reg;
    assign sum_data  = sd_reg;

endmodule

### src/weadc_region_out.sv
// Output stage: widen the active span by the margin, clamp, add the region base.
`timescale 1ns / 1ps

module weadc_region_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  weadc_pkg::cfg_t                     cfg,
    input  logic                                sum_valid,
    input  weadc_pkg::region_sum_t              sum_data,
    output logic                                sum_ready,
    output logic                                out_valid,
    input  logic                                out_stall,
    output weadc_pkg::out_item_t                out_data
);
    import weadc_pkg::*;

    logic                   ov_reg;
    out_item_t              od_reg, od_next;
    logic                   out_free, has_act;
    logic [OFFSET_BITS-1:0] lo, hi, base;
    logic [OFFSET_BITS:0]   hi_wide;

    assign out_free  = !ov_reg || !out_stall;
    assign sum_ready = out_free;

    always_comb
    begin
        has_act = sum_data.found && (sum_data.first_off < sum_data.last_off);
        base    = OFFSET_BITS'(cfg.region_start);
        lo      = (sum_data.first_off > OFFSET_BITS'(cfg.pad_len))
                  ? sum_data.first_off - OFFSET_BITS'(cfg.pad_len) : '0;
        hi_wide = (OFFSET_BITS+1)'(sum_data.last_off)
                  + (OFFSET_BITS+1)'(cfg.pad_len);
        hi      = (hi_wide > (OFFSET_BITS+1)'(sum_data.frames))
                  ? sum_data.frames : hi_wide[OFFSET_BITS-1:0];
        od_next.any_active   = has_act;
        od_next.active_start = has_act ? base + lo : base;
        od_next.active_end   = has_act ? base + hi : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && sum_valid)
        begin
            od_reg <= od_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

### src/windowed_energy_activity_detect_core.sv
// Top level of the windowed energy activity detector: config registers and stage wiring.
`timescale 1ns / 1ps

// Energy-threshold activity detector over interleaved signed samples, one sample
// per item. Each group of channel-count samples makes a frame and each group of
// window-length frames makes a window; a window is active when its sum of squares
// exceeds the energy threshold times its sample count. On the item flagged
// last_sample the block emits one result: the activity flag and the active span,
// widened by the pad length, clamped to the region and offset by region_start (both
// ends equal region_start when nothing was active); all region state then clears.
// Items are accepted one per cycle while the input is not stalled; each sample passes
// once through the square and the threshold multiply-accumulate. The input stalls
// only when a last-marked item finds both the summary register and the output
// register full while the output is stalled. A result passes through the
// input/square register, the accumulator summary register and the output register
// before it shows on out_valid. Write configuration only while no item is in flight;
// writes take effect at the next edge.

module windowed_energy_activity_detect_core #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  weadc_pkg::in_item_t                     in_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output weadc_pkg::out_item_t                    out_data,
    input  logic                                    cfg_we,
    input  logic [weadc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [weadc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import weadc_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    logic                take, sq_valid, sq_last, sum_valid, sum_ready;
    logic [SQ_BITS-1:0]  sq_value;
    region_sum_t         sum_data;

    // Register file: decode the index, ignore writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANS:        cfg_next.chans_per_frame = cfg_data[3:0];
                REG_WIN_LEN:      cfg_next.win_len         = cfg_data[15:0];
                REG_PAD_LEN:      cfg_next.pad_len         = cfg_data[23:0];
                REG_ENERGY_THR:   cfg_next.energy_thr      = cfg_data[THR_BITS-1:0];
                REG_REGION_START: cfg_next.region_start    = cfg_data[30:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chans_per_frame <= 4'd1;
            cfg_reg.win_len         <= 16'd480;
            cfg_reg.pad_len         <= 24'd0;
            cfg_reg.energy_thr      <= 31'd1073742;
            cfg_reg.region_start    <= 31'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Capture and square the sample; hold while the accumulator cannot take it
    weadc_square_stage u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .take     (take),
        .sq_valid (sq_valid),
        .sq_value (sq_value),
        .sq_last  (sq_last)
    );

    // Advance frame and window counters, judge windows, summarize the region
    weadc_accum #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sq_valid  (sq_valid),
        .sq_value  (sq_value),
        .sq_last   (sq_last),
        .take      (take),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_ready (sum_ready)
    );

    // Apply margin, clamp and region base into the result register
    weadc_region_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_ready (sum_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the windowed energy activity detector core.
`timescale 1ns / 1ps

module tb_top;
    import weadc_pkg::*;

    localparam int     CLK_NS             = 12;
    localparam int     RESET_CYCLES       = 4;
    localparam int     MAX_CHANNELS       = 8;
    // The square, summary and output registers sit between the last item and its result; leave slack.
    localparam int     DRAIN_CYCLES       = 6;
    localparam int     RANDOM_SAMPLES     = 1950;
    localparam int     HOLD_OFF_CYCLES    = 400;
    localparam int     HOLD_AFTER_REGIONS = 12;
    localparam longint LIMIT_CYCLES       = 800000;

    // Scoreboard: tracks the region state of the detector and queues the
    // region report that each last-marked sample must produce.
    class activity_scoreboard;
        bit [3:0]  chan_cfg;
        bit [15:0] win_cfg;
        bit [23:0] margin_cfg;
        bit [30:0] thr_cfg;
        bit [30:0] base_cfg;

        bit [63:0] energy;
        bit [31:0] win_samples;
        bit [31:0] chan_pos;
        bit [31:0] frame_pos;
        bit [31:0] win_begin;
        bit [31:0] first_hit;
        bit [31:0] last_hit;
        bit        hit;

        out_item_t pending_regions[$];
        int        errors;
        int        regions;
        int        active_regions;

        function new();
            chan_cfg       = 4'd1;
            win_cfg        = 16'd480;
            margin_cfg     = '0;
            thr_cfg        = 31'd1073742;
            base_cfg       = '0;
            errors         = 0;
            regions        = 0;
            active_regions = 0;
            clear_region();
        endfunction

        function void clear_region();
            energy      = '0;
            win_samples = '0;
            chan_pos    = '0;
            frame_pos   = '0;
            win_begin   = '0;
            first_hit   = '0;
            last_hit    = '0;
            hit         = 1'b0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_CHANS:        chan_cfg   = val[3:0];
                REG_WIN_LEN:      win_cfg    = val[15:0];
                REG_PAD_LEN:      margin_cfg = val[23:0];
                REG_ENERGY_THR:   thr_cfg    = val[30:0];
                REG_REGION_START: base_cfg   = val[30:0];
                default: ;
            endcase
        endfunction

        // Judge the window that ends at the current frame, then open the next one.
        function void close_window();
            bit [63:0] bound;
            if (win_samples != 0)
            begin
                bound = 64'(thr_cfg) * 64'(win_samples);
                if (energy > bound)
                begin
                    if (!hit)
                        first_hit = win_begin;
                    last_hit = frame_pos;
                    hit      = 1'b1;
                end
            end
            energy      = '0;
            win_samples = '0;
            win_begin   = frame_pos;
        endfunction

        function void accumulate_sample(in_item_t it);
            longint    s;
            bit [31:0] chans;
            bit [31:0] span;
            bit [31:0] lo;
            bit [63:0] hi;
            out_item_t want;
            s = longint'($signed(it.sample));
            chans = (chan_cfg == 0) ? 32'd1 :
                    (chan_cfg > MAX_CHANNELS) ? 32'(MAX_CHANNELS) : 32'(chan_cfg);
            span = (win_cfg == 0) ? 32'd1 : 32'(win_cfg);
            energy      = energy + 64'(s * s);
            win_samples = win_samples + 1;
            chan_pos    = chan_pos + 1;
            if (chan_pos >= chans || it.last_sample)
            begin
                chan_pos  = '0;
                frame_pos = frame_pos + 1;
                if (frame_pos - win_begin >= span || it.last_sample)
                    close_window();
            end
            if (!it.last_sample)
                return;
            if (hit && first_hit < last_hit)
            begin
                lo = (first_hit > margin_cfg) ? first_hit - margin_cfg : '0;
                hi = 64'(last_hit) + 64'(margin_cfg);
                if (hi > 64'(frame_pos))
                    hi = 64'(frame_pos);
                want.any_active   = 1'b1;
                want.active_start = 32'(base_cfg) + lo;
                want.active_end   = 32'(base_cfg) + hi[31:0];
                active_regions++;
            end
            else
            begin
                want.any_active   = 1'b0;
                want.active_start = 32'(base_cfg);
                want.active_end   = 32'(base_cfg);
            end
            pending_regions.push_back(want);
            regions++;
            clear_region();
        endfunction

        function int pending();
            return pending_regions.size();
        endfunction

        task flag_mismatch(string what, bit [63:0] got, bit [63:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_region(out_item_t got);
            out_item_t want;
            if (pending_regions.size() == 0)
            begin
                flag_mismatch("unexpected result, active_start", got.active_start, '0);
                return;
            end
            want = pending_regions.pop_front();
            if (got.any_active !== want.any_active)
                flag_mismatch("any_active", got.any_active, want.any_active);
            if (got.active_start !== want.active_start)
                flag_mismatch("active_start", got.active_start, want.active_start);
            if (got.active_end !== want.active_end)
                flag_mismatch("active_end", got.active_end, want.active_end);
        endtask
    endclass

    // Hold every input at a known value from time zero.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    in_item_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    activity_scoreboard sb;
    int samples_sent = 0;
    int reg_writes   = 0;
    int tx_calm      = 0;
    bit holding      = 1'b0;

    windowed_energy_activity_detect_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_NS / 2) clk = ~clk;
    end

    // Bound the run; a hung handshake lands here.
    initial
    begin
        #(CLK_NS * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    // Draw an idle length: mostly none or short, a few long, and now and then
    // a calm stretch of back-to-back cycles with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(40, 160);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mix quiet noise with loud content so windows land on both sides of the
    // threshold; pin the full-scale extremes now and then.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int loud_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'sh8000;
        if (r < 6)
            return 16'sh7FFF;
        if (r < loud_pct)
            return 16'($urandom);
        return 16'($urandom_range(0, 127)) - 16'sd64;
    endfunction

    // Favor small windows and margins; hit the register extremes regularly.
    function automatic cfg_t random_cfg();
        cfg_t c;
        case ($urandom_range(0, 9))
            0:       c.chans_per_frame = 4'd0;
            1:       c.chans_per_frame = 4'($urandom_range(9, 15));
            2:       c.chans_per_frame = 4'(MAX_CHANNELS);
            default: c.chans_per_frame = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       c.win_len = 16'd0;
            1:       c.win_len = 16'hFFFF;
            2:       c.win_len = 16'($urandom);
            3:       c.win_len = 16'($urandom_range(9, 64));
            default: c.win_len = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0:       c.pad_len = '0;
            1:       c.pad_len = 24'hFFFFFF;
            2:       c.pad_len = 24'($urandom);
            default: c.pad_len = 24'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       c.energy_thr = '0;
            1:       c.energy_thr = 31'd1073741824;
            2:       c.energy_thr = 31'h7FFFFFFF;
            3:       c.energy_thr = 31'($urandom);
            default: c.energy_thr = 31'($urandom_range(1 << 20, 1 << 29));
        endcase
        case ($urandom_range(0, 3))
            0:       c.region_start = '0;
            1:       c.region_start = 31'h7FFFFFFF;
            default: c.region_start = 31'($urandom);
        endcase
        return c;
    endfunction

    // Write one register, then drop the enable so writes never overlap.
    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_regs(input bit [4:0] which, input cfg_t c);
        if (which[0]) put_reg(REG_CHANS, 31'(c.chans_per_frame));
        if (which[1]) put_reg(REG_WIN_LEN, 31'(c.win_len));
        if (which[2]) put_reg(REG_PAD_LEN, 31'(c.pad_len));
        if (which[3]) put_reg(REG_ENERGY_THR, 31'(c.energy_thr));
        if (which[4]) put_reg(REG_REGION_START, 31'(c.region_start));
    endtask

    // Offer one item and hold it until the core takes it, then idle a while.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input bit last);
        in_item_t it;
        int       gap;
        it.sample      = value;
        it.last_sample = last;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.accumulate_sample(it);
        samples_sent++;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain: drop valid, wait for every queued report, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check every accepted report and stall at random. Once a few
    // regions have come back, wait until the sender is offering an item, then
    // hold off for a long stretch so the core backs up and has to stall its input.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int calm;
        int seen;
        bit held;
        stall_left = 0;
        hold_left  = 0;
        calm       = 0;
        seen       = 0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_region(out_data);
                seen++;
            end
            if (!held && seen >= HOLD_AFTER_REGIONS && in_valid)
            begin
                held      = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                holding   = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                holding   = (hold_left > 0);
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = pick_gap(calm);
            end
        end
    end

    initial
    begin : stimulus
        int first_random;
        int len;
        int loud;
        int split;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Zero threshold, one-frame windows: silence, both full-scale values,
        // the smallest negative, then silence closing the region.
        put_reg(REG_CHANS, 31'd1);
        put_reg(REG_WIN_LEN, 31'd1);
        put_reg(REG_PAD_LEN, 31'd0);
        put_reg(REG_ENERGY_THR, 31'd0);
        put_reg(REG_REGION_START, 31'd0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);

        // Mean square exactly at full-scale threshold: not active. A zero
        // channel count behaves as one; region start at its top.
        settle();
        put_reg(REG_ENERGY_THR, 31'd1073741824);
        put_reg(REG_REGION_START, 31'h7FFFFFFF);
        put_reg(REG_CHANS, 31'd0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Oversized channel count clamps to the maximum; one huge window, a
        // margin wide enough to clamp both ends, and a partial frame at the end.
        settle();
        put_reg(REG_CHANS, 31'd15);
        put_reg(REG_WIN_LEN, 31'hFFFF);
        put_reg(REG_PAD_LEN, 31'hFFFFFF);
        put_reg(REG_ENERGY_THR, 31'd0);
        for (int k = 0; k < 10; k++)
            send_sample(16'sh7FFF, k == 9);

        // Region of a single sample.
        settle();
        put_reg(REG_CHANS, 31'd3);
        send_sample(16'sd1, 1'b1);

        // Zero window length acts as one; shrink the channel count mid-frame
        // so the frame completes past the new count.
        settle();
        put_reg(REG_CHANS, 31'd4);
        put_reg(REG_WIN_LEN, 31'd0);
        put_reg(REG_PAD_LEN, 31'd1);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b0);
        settle();
        put_reg(REG_CHANS, 31'd2);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd200, 1'b1);

        // Random regions: mostly short, a few long; reconfigure between regions
        // now and then, and rarely in the middle of one. Skip reconfiguration
        // while the receiver holds off, so the sender keeps pushing.
        first_random = samples_sent;
        while (samples_sent - first_random < RANDOM_SAMPLES)
        begin
            if (!holding && $urandom_range(0, 3) == 0)
            begin
                settle();
                write_regs(5'($urandom_range(1, 31)), random_cfg());
            end
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 150) : $urandom_range(1, 30);
            loud  = $urandom_range(0, 100);
            split = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++)
            begin
                if (k == split && k > 0 && !holding)
                begin
                    settle();
                    write_regs(5'($urandom_range(1, 31)), random_cfg());
                end
                send_sample(pick_sample(loud), k == len - 1);
            end
        end

        settle();
        $display("Drove %0d samples over %0d regions (%0d active) with %0d register writes.",
                 samples_sent, sb.regions, sb.active_regions, reg_writes);
        $display("Output held off once for %0d cycles; %0d mismatches seen.",
                 HOLD_OFF_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
